### src/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/crc16cfr_pkg.sv
// Package: constants, result type and CRC update for the command frame receiver.
`timescale 1ns / 1ps

package crc16cfr_pkg;

	localparam int MAX_FRAME_BYTES = 255;
	localparam int HDR_TRL_BYTES = 5;
	localparam int BC_W = $clog2(MAX_FRAME_BYTES + 1);

	localparam logic [15:0] CRC_SEED_RESET = 16'hC181;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int APB_AW = 2;
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_SHORT = 2'd2,
		ST_LONG = 2'd3
	} status_t;

	typedef struct packed {
		logic kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [15:0] node_id;
		logic [7:0] frame_command;
		logic [7:0] payload_size;
		logic [1:0] status;
		logic last;
	} res_t;

	// Reflected CRC-16 update over one byte, LSB first.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### src/crc16_command_frame_receiver.sv
// A byte is registered in s1, then written into the result queue.
// Throughput: one byte per cycle while the queue has room; a closing byte that
// releases a payload byte gives two results, drained one per cycle while res_stall
// is low, from a four-entry queue. The CRC byte update after s1 is combinational.
// Reset clears frame state and the queue and loads crc_seed with 0xC181.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module crc16_command_frame_receiver import crc16cfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic rx_valid,
	output logic rx_stall,
	input  logic [7:0] rx_byte,
	input  logic frame_end,
	output logic res_valid,
	input  logic res_stall,
	output logic kind,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [15:0] node_id,
	output logic [7:0] frame_command,
	output logic [7:0] payload_size,
	output logic [1:0] status,
	output logic last
);

	localparam logic [BC_W-1:0] MAX_BC = BC_W'(MAX_FRAME_BYTES);
	localparam logic [BC_W-1:0] HDR_BC = BC_W'(HDR_TRL_BYTES);
	localparam logic [7:0] OVF_SIZE = 8'(MAX_FRAME_BYTES - HDR_TRL_BYTES);

	// configuration
	logic [15:0] crc_seed_q;
	logic seed_sel;

	assign pready = 1'b1;
	assign seed_sel = (paddr[1] == 1'b0);
	assign prdata = seed_sel ? {16'h0000, crc_seed_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q <= CRC_SEED_RESET;
		end else if (psel && penable && pwrite && pready && seed_sel) begin
			crc_seed_q <= pwdata[15:0];
		end
	end

	// input register
	logic valid_s1;
	logic [7:0] byte_s1;
	logic end_s1;
	logic fire_s1;
	logic load_s1;

	assign rx_stall = valid_s1 && !fire_s1;
	assign load_s1 = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= rx_byte;
			end_s1 <= frame_end;
		end
	end

	// frame state
	logic [15:0] crc_acc_q;
	logic [BC_W-1:0] byte_count_q;
	logic [7:0] hold_older_q;
	logic [7:0] hold_newer_q;
	logic [15:0] id_q;
	logic [7:0] cmd_q;
	logic overflow_q;

	logic [15:0] crc_nx;
	logic [BC_W-1:0] count_nx;
	logic [7:0] older_nx;
	logic [7:0] newer_nx;
	logic [15:0] id_nx;
	logic [7:0] cmd_nx;
	logic ovf_nx;
	logic in_range;
	logic emit_pay;
	logic [1:0] n_res;
	res_t pay_res;
	res_t stat_res;
	status_t st;
	logic [7:0] size;

	assign in_range = (byte_count_q < MAX_BC);
	assign emit_pay = in_range && (byte_count_q >= HDR_BC);
	assign n_res = {1'b0, emit_pay} + {1'b0, end_s1};

	always_comb begin
		crc_nx = crc_acc_q;
		count_nx = byte_count_q;
		older_nx = hold_older_q;
		newer_nx = hold_newer_q;
		id_nx = id_q;
		cmd_nx = cmd_q;
		ovf_nx = overflow_q;
		if (in_range) begin
			if (byte_count_q == '0) begin
				crc_nx = crc_seed_q;
				id_nx = {8'h00, byte_s1};
			end else if (byte_count_q == BC_W'(1)) begin
				id_nx = {byte_s1, id_q[7:0]};
			end else begin
				if (byte_count_q == BC_W'(2)) begin
					cmd_nx = byte_s1;
				end
				crc_nx = crc_fold(crc_acc_q, hold_older_q);
			end
			older_nx = hold_newer_q;
			newer_nx = byte_s1;
			count_nx = byte_count_q + BC_W'(1);
		end else begin
			ovf_nx = 1'b1;
		end
	end

	always_comb begin
		if (ovf_nx) begin
			st = ST_LONG;
			size = OVF_SIZE;
		end else if (count_nx < HDR_BC) begin
			st = ST_SHORT;
			size = 8'h00;
		end else begin
			st = (crc_nx == {newer_nx, older_nx}) ? ST_OK : ST_CRC_ERR;
			size = 8'(count_nx - HDR_BC);
		end
	end

	always_comb begin
		pay_res = '0;
		pay_res.kind = KIND_PAYLOAD;
		pay_res.payload_byte = hold_older_q;
		pay_res.payload_index = 8'(byte_count_q - HDR_BC);
		pay_res.last = !end_s1;
		stat_res = '0;
		stat_res.kind = KIND_STATUS;
		stat_res.node_id = id_nx;
		stat_res.frame_command = cmd_nx;
		stat_res.payload_size = size;
		stat_res.status = st;
		stat_res.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc_q <= CRC_SEED_RESET;
			byte_count_q <= '0;
			hold_older_q <= '0;
			hold_newer_q <= '0;
			id_q <= '0;
			cmd_q <= '0;
			overflow_q <= 1'b0;
		end else if (fire_s1) begin
			if (end_s1) begin
				crc_acc_q <= crc_seed_q;
				byte_count_q <= '0;
				hold_older_q <= '0;
				hold_newer_q <= '0;
				id_q <= '0;
				cmd_q <= '0;
				overflow_q <= 1'b0;
			end else begin
				crc_acc_q <= crc_nx;
				byte_count_q <= count_nx;
				hold_older_q <= older_nx;
				hold_newer_q <= newer_nx;
				id_q <= id_nx;
				cmd_q <= cmd_nx;
				overflow_q <= ovf_nx;
			end
		end
	end

	// result queue
	res_t q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] room;
	logic [QPTR_W-1:0] stat_ptr;
	logic pop;
	logic [QCNT_W-1:0] n_wr;
	res_t head;

	assign room = QCNT_W'(QDEPTH) - count_q;
	assign fire_s1 = valid_s1 && (QCNT_W'(n_res) <= room);
	assign pop = res_valid && !res_stall;
	assign n_wr = fire_s1 ? QCNT_W'(n_res) : '0;
	assign stat_ptr = wr_ptr_q + QPTR_W'(emit_pay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_wr);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q <= count_q + n_wr - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_pay) begin
			q_q[wr_ptr_q] <= pay_res;
		end
		if (fire_s1 && end_s1) begin
			q_q[stat_ptr] <= stat_res;
		end
	end

	assign head = q_q[rd_ptr_q];
	assign res_valid = (count_q != '0);
	assign kind = head.kind;
	assign payload_byte = head.payload_byte;
	assign payload_index = head.payload_index;
	assign node_id = head.node_id;
	assign frame_command = head.frame_command;
	assign payload_size = head.payload_size;
	assign status = head.status;
	assign last = head.last;

	`ASSERT_ALWAYS(a_q_bound, count_q <= QCNT_W'(QDEPTH), "result queue over capacity")
	`ASSERT_ALWAYS(a_bc_bound, byte_count_q <= MAX_BC, "byte count beyond frame limit")
	`ASSERT_NEXT(a_end_clear, fire_s1 && end_s1, byte_count_q == '0 && !overflow_q, "frame state not cleared after closing item")
	`ASSERT_NEXT(a_s1_hold, valid_s1 && !fire_s1, valid_s1 && $stable(byte_s1) && $stable(end_s1), "blocked item in s1 lost")

endmodule
